[hdl/csv_pkg.sv]
// Shared types and constants for the scanline and vignette pixel filter.
// Used by every module of the block; depends on nothing else.

package csv_pkg;

  // Screen geometry in pixels.
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;

  // Field widths.
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CHAN_W  = 8;

  // Distance datapath: offsets in half pixels, squared radius, square root.
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned SQ_W        = 2 * DIFF_W;
  localparam int unsigned RAD_W       = SQ_W + 2;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 3;
  localparam int unsigned SQRT_STAGES = 3;
  localparam int unsigned SQRT_DIGITS = ROOT_W / SQRT_STAGES;

  // Integer square root used to size the vignette at elaboration.
  function automatic int unsigned isqrt_const(input int unsigned v);
    int unsigned res;
    int unsigned rem;
    int unsigned b;
    res = 0;
    rem = v;
    for (int k = 15; k >= 0; k--) begin
      b = 32'd1 << (2 * k);
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Smoothstep edges: half the corner distance up to the full corner distance.
  localparam int unsigned CORNER_DIST =
    isqrt_const(SCREEN_WIDTH * SCREEN_WIDTH + SCREEN_HEIGHT * SCREEN_HEIGHT);
  localparam int unsigned EDGE0 = CORNER_DIST / 2;
  localparam int unsigned EDGE1 = CORNER_DIST;
  localparam int unsigned SPAN  = EDGE1 - EDGE0;

  localparam logic [ROOT_W-1:0] EDGE0_D = ROOT_W'(EDGE0);
  localparam logic [ROOT_W-1:0] EDGE1_D = ROOT_W'(EDGE1);

  // Gain is Q1.15.
  localparam int unsigned GAIN_FRAC = 15;
  localparam int unsigned GAIN_W    = GAIN_FRAC + 1;
  localparam int unsigned GAIN_ONE  = 1 << GAIN_FRAC;
  localparam int unsigned POLY_W    = GAIN_W + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE_D  = GAIN_W'(GAIN_ONE);
  localparam logic [POLY_W-1:0] THREE_ONE_D = POLY_W'(3 * GAIN_ONE);

  // Ramp position: (d - EDGE0) * 2^15 / SPAN by a reciprocal multiply. The
  // offset stays below SPAN (at most 724 for any legal screen), so a shift
  // of 10 keeps the estimate within one of the true quotient.
  localparam int unsigned SPAN_W      = 10;
  localparam int unsigned NUM_W       = SPAN_W + GAIN_FRAC;
  localparam int unsigned RECIP_SHIFT = 10;
  localparam int unsigned RECIP_W     = GAIN_FRAC + RECIP_SHIFT + 1;
  localparam int unsigned RECIP       = (2 ** (GAIN_FRAC + RECIP_SHIFT)) / SPAN;
  localparam logic [SPAN_W-1:0]  SPAN_D  = SPAN_W'(SPAN);
  localparam logic [NUM_W-1:0]   SPAN_N  = NUM_W'(SPAN);
  localparam logic [RECIP_W-1:0] RECIP_D = RECIP_W'(RECIP);

  // Scanline dimming by 4/5: (c * 820) >> 10 is exact for every 8-bit value.
  localparam int unsigned SCAN_NUM   = 4;
  localparam int unsigned SCAN_DEN   = 5;
  localparam int unsigned SCAN_SHIFT = 10;
  localparam int unsigned SCAN_MUL_W = 10;
  localparam int unsigned SCAN_MUL   =
    (SCAN_NUM * (2 ** SCAN_SHIFT) + SCAN_DEN - 1) / SCAN_DEN;
  localparam logic [SCAN_MUL_W-1:0] SCAN_MUL_D = SCAN_MUL_W'(SCAN_MUL);

  // Pipeline stage numbering.
  localparam int unsigned ST_IN      = 0;
  localparam int unsigned ST_SQ      = 1;
  localparam int unsigned ST_ROOT0   = 2;
  localparam int unsigned ST_DIV     = ST_ROOT0 + SQRT_STAGES;
  localparam int unsigned ST_T       = ST_DIV + 1;
  localparam int unsigned ST_TSQ     = ST_T + 1;
  localparam int unsigned ST_GAIN    = ST_TSQ + 1;
  localparam int unsigned ST_OUT     = ST_GAIN + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;
  localparam int unsigned OCC_W      = $clog2(NUM_STAGES + 1);

  // One load enable per stage.
  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCANLINE_EN = 1'b0,
    REG_VIGNETTE_EN = 1'b1
  } cfg_reg_t;

  localparam logic SCAN_EN_RST = 1'b1;
  localparam logic VIG_EN_RST  = 1'b1;

endpackage

[hdl/csv_isqrt.sv]
// Pipelined integer square root of the squared distance, a few digits a stage.
// Depends on csv_pkg for widths and stage numbering.

module csv_isqrt
  import csv_pkg::*;
(
  input  logic              clk,
  input  stage_vec_t        adv,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_step_t;

  // Restoring digit recurrence, one result bit per step.
  function automatic sqrt_step_t sqrt_digits(input sqrt_step_t s_in);
    sqrt_step_t s;
    logic [REM_W-1:0] rem_v;
    logic [REM_W-1:0] trial;
    s = s_in;
    for (int i = 0; i < SQRT_DIGITS; i++) begin
      rem_v = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      trial = REM_W'({s.root, 2'b01});
      if (rem_v >= trial) begin
        s.rem  = rem_v - trial;
        s.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        s.rem  = rem_v;
        s.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      s.rad = {s.rad[RAD_W-3:0], 2'b00};
    end
    return s;
  endfunction

  logic [REM_W-1:0]  rem_r  [SQRT_STAGES-1];
  logic [RAD_W-1:0]  rad_r  [SQRT_STAGES-1];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];

  genvar g;
  for (g = 0; g < SQRT_STAGES; g++) begin : g_stage
    sqrt_step_t st_in;
    sqrt_step_t st_nxt;

    // First stage starts from the radicand; later ones from the stage before.
    if (g == 0) begin : g_first
      assign st_in = '{rem: '0, root: '0, rad: rad};
    end else begin : g_next
      assign st_in = '{rem: rem_r[g-1], root: root_r[g-1], rad: rad_r[g-1]};
    end

    assign st_nxt = sqrt_digits(st_in);

    // Partial remainder and unused radicand bits move on to the next stage.
    if (g < SQRT_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[ST_ROOT0 + g]) begin
          rem_r[g] <= st_nxt.rem;
          rad_r[g] <= st_nxt.rad;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[ST_ROOT0 + g]) begin
        root_r[g] <= st_nxt.root;
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

[hdl/csv_gain.sv]
// Vignette gain pipeline: ramp position, smoothstep and the Q1.15 gain.
// Depends on csv_pkg for the edges, the reciprocal and stage numbering.

module csv_gain
  import csv_pkg::*;
(
  input  logic              clk,
  input  stage_vec_t        adv,
  input  logic [ROOT_W-1:0] distance,
  output logic [GAIN_W-1:0] gain
);

  logic [SPAN_W-1:0]         x_nxt;
  logic [SPAN_W+RECIP_W-1:0] q_prod;
  logic [SPAN_W-1:0]         x_r;
  logic [GAIN_FRAC-1:0]      q0_r;
  logic                      lo_r;
  logic                      hi_r;

  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  back;
  logic [NUM_W-1:0]  rem;
  logic [GAIN_W-1:0] q;
  logic [GAIN_W-1:0] t_nxt;
  logic [GAIN_W-1:0] t_r;

  logic [2*GAIN_W-1:0]        tsq_full;
  logic [GAIN_W-1:0]          tsq_r;
  logic [GAIN_W-1:0]          t_d_r;
  logic [POLY_W-1:0]          poly;
  logic [GAIN_W+POLY_W-1:0]   s_full;
  logic [GAIN_W-1:0]          gain_nxt;
  logic [GAIN_W-1:0]          gain_r;

  // Offset into the ramp and a quotient estimate by reciprocal multiply.
  assign x_nxt  = SPAN_W'(distance - EDGE0_D);
  assign q_prod = {{RECIP_W{1'b0}}, x_nxt} * {{SPAN_W{1'b0}}, RECIP_D};

  always_ff @(posedge clk) begin
    if (adv[ST_DIV]) begin
      x_r  <= x_nxt;
      q0_r <= q_prod[RECIP_SHIFT +: GAIN_FRAC];
      lo_r <= (distance <= EDGE0_D);
      hi_r <= (distance >= EDGE1_D);
    end
  end

  // The estimate is at most one low; fix it with one compare, then saturate.
  assign num  = {x_r, {GAIN_FRAC{1'b0}}};
  assign back = {{SPAN_W{1'b0}}, q0_r} * {{GAIN_FRAC{1'b0}}, SPAN_D};
  assign rem  = num - back;
  assign q    = (rem >= SPAN_N) ? GAIN_W'(q0_r) + GAIN_W'(1) : GAIN_W'(q0_r);

  always_comb begin
    if (lo_r) begin
      t_nxt = '0;
    end else if (hi_r) begin
      t_nxt = GAIN_ONE_D;
    end else begin
      t_nxt = q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_T]) begin
      t_r <= t_nxt;
    end
  end

  // Square of the ramp position.
  assign tsq_full = {{GAIN_W{1'b0}}, t_r} * {{GAIN_W{1'b0}}, t_r};

  always_ff @(posedge clk) begin
    if (adv[ST_TSQ]) begin
      tsq_r <= tsq_full[GAIN_FRAC +: GAIN_W];
      t_d_r <= t_r;
    end
  end

  // Smoothstep t^2 * (3 - 2t), and the gain is one minus that.
  assign poly     = THREE_ONE_D - {t_d_r, 1'b0};
  assign s_full   = {{POLY_W{1'b0}}, tsq_r} * {{GAIN_W{1'b0}}, poly};
  assign gain_nxt = GAIN_ONE_D - s_full[GAIN_FRAC +: GAIN_W];

  always_ff @(posedge clk) begin
    if (adv[ST_GAIN]) begin
      gain_r <= gain_nxt;
    end
  end

  assign gain = gain_r;

endmodule

[hdl/crt_scanline_vignette_filter.sv]
// Top level of the scanline and radial vignette pixel filter.
// Depends on csv_pkg, csv_isqrt and csv_gain.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   column, line, red, green, blue
//   out_     output     out_valid / out_stall red, green, blue
//   cfg_     input      cfg_wr_en             index, write data
//
// One pixel per clock unless a stalled output has filled the pipeline; a pixel
// passes from its transfer in to the output register through the ten register
// stages (three in the square root).
// Reset clears all valid bits and turns both scanlines and vignette on.
// A stage holds only while the one after it is full and held, so empty
// stages keep filling while a result waits at the output.

module crt_scanline_vignette_filter
  import csv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   in_column,
  input  logic [COORD_W-1:0]   in_line,
  input  logic [CHAN_W-1:0]    in_red_in,
  input  logic [CHAN_W-1:0]    in_green_in,
  input  logic [CHAN_W-1:0]    in_blue_in,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAN_W-1:0]    out_red_out,
  output logic [CHAN_W-1:0]    out_green_out,
  output logic [CHAN_W-1:0]    out_blue_out,

  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  localparam logic [DIFF_W-1:0] SCREEN_W_D = DIFF_W'(SCREEN_WIDTH);
  localparam logic [DIFF_W-1:0] SCREEN_H_D = DIFF_W'(SCREEN_HEIGHT);

  logic scan_en_r;
  logic vig_en_r;

  stage_vec_t vld_r;
  stage_vec_t vld_nxt;
  stage_vec_t adv;

  logic [DIFF_W-1:0] two_col;
  logic [DIFF_W-1:0] two_row;
  logic [DIFF_W-1:0] dx_nxt;
  logic [DIFF_W-1:0] dy_nxt;
  logic [DIFF_W-1:0] dx_r;
  logic [DIFF_W-1:0] dy_r;
  logic [SQ_W-1:0]   dx_sq;
  logic [SQ_W-1:0]   dy_sq;
  logic [RAD_W-1:0]  rad_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] distance;
  logic [GAIN_W-1:0] gain;

  pixel_t in_pix;
  pixel_t pix_nxt;
  pixel_t pix_r [ST_GAIN+1];
  pixel_t out_pix_nxt;
  pixel_t out_pix_r;

  // Four fifths of a channel, truncated.
  function automatic logic [CHAN_W-1:0] scan_dim(input logic [CHAN_W-1:0] c);
    logic [CHAN_W+SCAN_MUL_W-1:0] p;
    p = {{SCAN_MUL_W{1'b0}}, c} * {{CHAN_W{1'b0}}, SCAN_MUL_D};
    return p[SCAN_SHIFT +: CHAN_W];
  endfunction

  // Channel times Q1.15 gain, truncated and clamped to full scale.
  function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                   input logic [GAIN_W-1:0] g);
    logic [CHAN_W+GAIN_W-1:0] p;
    logic [CHAN_W:0]          v;
    p = {{GAIN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, g};
    v = p[GAIN_FRAC +: CHAN_W+1];
    return v[CHAN_W] ? {CHAN_W{1'b1}} : v[CHAN_W-1:0];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= SCAN_EN_RST;
      vig_en_r  <= VIG_EN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCANLINE_EN: scan_en_r <= cfg_wdata;
        REG_VIGNETTE_EN: vig_en_r  <= cfg_wdata;
      endcase
    end
  end

  // Stage load enables: a stage loads when it is empty or the next one loads.
  always_comb begin
    adv[ST_OUT] = !vld_r[ST_OUT] || !out_stall;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[ST_IN];

  always_comb begin
    vld_nxt[ST_IN] = adv[ST_IN] ? in_valid : vld_r[ST_IN];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Input stage: offsets from the center in half pixels, scanline dimming.
  assign two_col = {in_column, 1'b0};
  assign two_row = {in_line, 1'b0};
  assign dx_nxt  = (two_col >= SCREEN_W_D) ? two_col - SCREEN_W_D : SCREEN_W_D - two_col;
  assign dy_nxt  = (two_row >= SCREEN_H_D) ? two_row - SCREEN_H_D : SCREEN_H_D - two_row;

  assign in_pix = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  always_comb begin
    if (scan_en_r && !in_line[0]) begin
      pix_nxt = '{red:   scan_dim(in_pix.red),
                  green: scan_dim(in_pix.green),
                  blue:  scan_dim(in_pix.blue)};
    end else begin
      pix_nxt = in_pix;
    end
  end

  // Squared distance.
  assign dx_sq   = {{DIFF_W{1'b0}}, dx_r} * {{DIFF_W{1'b0}}, dx_r};
  assign dy_sq   = {{DIFF_W{1'b0}}, dy_r} * {{DIFF_W{1'b0}}, dy_r};
  assign rad_nxt = RAD_W'(dx_sq) + RAD_W'(dy_sq);

  // Coordinate registers and the pixel delay line alongside the gain path.
  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      dx_r         <= dx_nxt;
      dy_r         <= dy_nxt;
      pix_r[ST_IN] <= pix_nxt;
    end
    if (adv[ST_SQ]) begin
      rad_r <= rad_nxt;
    end
    for (int k = 1; k <= ST_GAIN; k++) begin
      if (adv[k]) begin
        pix_r[k] <= pix_r[k-1];
      end
    end
  end

  csv_isqrt u_isqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (rad_r),
    .root (distance)
  );

  csv_gain u_gain (
    .clk      (clk),
    .adv      (adv),
    .distance (distance),
    .gain     (gain)
  );

  // Output stage: apply the vignette gain.
  always_comb begin
    if (vig_en_r) begin
      out_pix_nxt = '{red:   scale_chan(pix_r[ST_GAIN].red, gain),
                      green: scale_chan(pix_r[ST_GAIN].green, gain),
                      blue:  scale_chan(pix_r[ST_GAIN].blue, gain)};
    end else begin
      out_pix_nxt = pix_r[ST_GAIN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_valid     = vld_r[ST_OUT];
  assign out_red_out   = out_pix_r.red;
  assign out_green_out = out_pix_r.green;
  assign out_blue_out  = out_pix_r.blue;

endmodule

[hdl/csv_checker.sv]
// Port-level checks for the scanline and vignette filter, bound to the top.
// Depends on csv_pkg for the pipeline depth.

module csv_assert
  import csv_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAN_W-1:0] out_red_out,
  input logic [CHAN_W-1:0] out_green_out,
  input logic [CHAN_W-1:0] out_blue_out
);

  logic             in_xfer;
  logic             out_xfer;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // Pixels transferred in and not yet transferred out.
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign occ_nxt  = occ_r + OCC_W'(in_xfer) - OCC_W'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A held result keeps its valid and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out))
    else $error("held output changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // With the output free, every stage can move and the input is open.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // Every result belongs to a pixel that came in.
  a_out_backed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("result without a pixel in flight");

  // No more pixels in flight than the pipeline has stages.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(NUM_STAGES))
    else $error("more pixels in flight than stages");

endmodule

bind crt_scanline_vignette_filter csv_assert u_csv_assert (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out)
);

[dv/csv_checker.sv]
// Checker for the scanline and vignette pixel filter: watches the pixel and result channels
// and the register port, predicts every filtered pixel and compares it with the result.
// Depends on csv_pkg.
`timescale 1ns / 1ps

module csv_checker
  import csv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [COORD_W-1:0]   in_column,
  input  logic [COORD_W-1:0]   in_line,
  input  logic [CHAN_W-1:0]    in_red_in,
  input  logic [CHAN_W-1:0]    in_green_in,
  input  logic [CHAN_W-1:0]    in_blue_in,

  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CHAN_W-1:0]    out_red_out,
  input  logic [CHAN_W-1:0]    out_green_out,
  input  logic [CHAN_W-1:0]    out_blue_out,

  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,

  output int unsigned          mismatches,
  output int unsigned          backlog
);

  // Shadow copy of the two enables and the filtered pixels still owed by the block.
  logic        scan_on;
  logic        vig_on;
  pixel_t      owed_px[$];
  int unsigned fails;

  // Floor of the square root, built one result bit at a time.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Q1.15 darkening gain: one minus a smoothstep of the distance from the center,
  // with offsets in half pixels.
  function automatic longint unsigned falloff_gain(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
    longint unsigned x2, y2, dx, dy, d;
    longint unsigned corner, e0, e1, t, t2, s;
    x2 = 64'(col);
    x2 = x2 << 1;
    y2 = 64'(row);
    y2 = y2 << 1;
    dx = (x2 >= SCREEN_WIDTH) ? x2 - SCREEN_WIDTH : SCREEN_WIDTH - x2;
    dy = (y2 >= SCREEN_HEIGHT) ? y2 - SCREEN_HEIGHT : SCREEN_HEIGHT - y2;
    d = floor_root(dx * dx + dy * dy);
    corner = floor_root(64'(SCREEN_WIDTH) * SCREEN_WIDTH + 64'(SCREEN_HEIGHT) * SCREEN_HEIGHT);
    e0 = corner >> 1;
    e1 = corner;
    if (e1 == e0) begin
      // Degenerate ramp: a hard step at the edge.
      s = (d < e0) ? 0 : GAIN_ONE;
    end else begin
      if (d <= e0) t = 0;
      else if (d >= e1) t = GAIN_ONE;
      else t = ((d - e0) << GAIN_FRAC) / (e1 - e0);
      t2 = (t * t) >> GAIN_FRAC;
      s = (t2 * (3 * GAIN_ONE - 2 * t)) >> GAIN_FRAC;
    end
    return GAIN_ONE - s;
  endfunction

  // Full filter for one pixel under the given enables.
  function automatic pixel_t filter_pixel(input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input pixel_t px, input logic scan,
                                          input logic vig);
    longint unsigned ch [3];
    longint unsigned g;
    pixel_t res;
    ch[0] = 64'(px.red);
    ch[1] = 64'(px.green);
    ch[2] = 64'(px.blue);
    if (scan && !row[0]) begin
      foreach (ch[i]) ch[i] = (ch[i] * SCAN_NUM) / SCAN_DEN;
    end
    if (vig) begin
      g = falloff_gain(col, row);
      foreach (ch[i]) begin
        ch[i] = (ch[i] * g) >> GAIN_FRAC;
        if (ch[i] > 255) ch[i] = 255;
      end
    end
    res.red   = CHAN_W'(ch[0]);
    res.green = CHAN_W'(ch[1]);
    res.blue  = CHAN_W'(ch[2]);
    return res;
  endfunction

  // Track register writes, predict on every pixel transfer and compare on every
  // result transfer.
  always @(posedge clk) begin
    pixel_t src;
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      scan_on = SCAN_EN_RST;
      vig_on  = VIG_EN_RST;
      owed_px.delete();
      fails = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCANLINE_EN: scan_on = cfg_wdata;
          REG_VIGNETTE_EN: vig_on  = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        src.red   = in_red_in;
        src.green = in_green_in;
        src.blue  = in_blue_in;
        owed_px.push_back(filter_pixel(in_column, in_line, src, scan_on, vig_on));
      end

      if (out_valid && !out_stall) begin
        got.red   = out_red_out;
        got.green = out_green_out;
        got.blue  = out_blue_out;
        if (owed_px.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with none pending: r=%0d g=%0d b=%0d",
                     $realtime, got.red, got.green, got.blue);
        end else begin
          want = owed_px.pop_front();
          if (got.red != want.red || got.green != want.green || got.blue != want.blue) begin
            fails++;
            if (fails <= 10)
              $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
    end
    mismatches <= fails;
    backlog    <= owed_px.size();
  end

endmodule

[dv/testbench.sv]
// Top of the pixel filter testbench: clock, reset, pixel stimulus, result stalls,
// register writes and the verdict. Depends on csv_pkg, csv_checker and the filter RTL.
`timescale 1ns / 1ps

module testbench
  import csv_pkg::*;
;

  logic               clk;
  logic               rst_n       = 1'b0;

  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] in_column   = '0;
  logic [COORD_W-1:0] in_line     = '0;
  logic [CHAN_W-1:0]  in_red_in   = '0;
  logic [CHAN_W-1:0]  in_green_in = '0;
  logic [CHAN_W-1:0]  in_blue_in  = '0;

  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [CHAN_W-1:0]  out_red_out;
  logic [CHAN_W-1:0]  out_green_out;
  logic [CHAN_W-1:0]  out_blue_out;

  logic               cfg_wr_en   = 1'b0;
  cfg_reg_t           cfg_index   = REG_SCANLINE_EN;
  logic               cfg_wdata   = 1'b0;

  int unsigned        mismatches;
  int unsigned        backlog;

  // Long hold-off of the result side, and the run-length counters for calm stretches.
  logic               squeeze     = 1'b0;
  logic               squeeze_req = 1'b0;
  int unsigned        tx_calm_left = 0;
  int unsigned        rx_calm_left = 0;
  int unsigned        stall_left   = 0;

  crt_scanline_vignette_filter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_column     (in_column),
    .in_line       (in_line),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  csv_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_column     (in_column),
    .in_line       (in_line),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .backlog       (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: after each transfer, a random stall, with calm stretches
  // and the long hold-off on top.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rx_calm_left > 0) begin
          rx_calm_left--;
          stall_left = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          rx_calm_left = 30;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 4);
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= squeeze || (stall_left != 0);
    end
  end

  // One long hold-off, so the pipeline fills and stalls its input.
  initial begin
    while (!squeeze_req) @(posedge clk);
    squeeze <= 1'b1;
    repeat (64) @(posedge clk);
    squeeze <= 1'b0;
  end

  // Offer one pixel after a random gap and wait for its transfer.
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    int unsigned gap;
    gap = 0;
    if (tx_calm_left > 0) tx_calm_left--;
    else if ($urandom_range(0, 19) == 0) tx_calm_left = 30;
    else gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_column   <= col;
    in_line     <= row;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random pixel: mostly on screen, some on the screen border, some anywhere in
  // the coordinate range; channels lean toward their extremes now and then.
  task automatic random_pixel();
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAN_W-1:0]  ch [3];
    case ($urandom_range(0, 7))
      0: begin
        col = COORD_W'($urandom);
        row = COORD_W'($urandom);
      end
      1: begin
        col = $urandom_range(0, 1) ? COORD_W'(SCREEN_WIDTH - 1) : '0;
        row = COORD_W'($urandom_range(0, SCREEN_HEIGHT - 1));
      end
      default: begin
        col = COORD_W'($urandom_range(0, SCREEN_WIDTH - 1));
        row = COORD_W'($urandom_range(0, SCREEN_HEIGHT - 1));
      end
    endcase
    foreach (ch[i]) begin
      case ($urandom_range(0, 7))
        0:       ch[i] = '0;
        1:       ch[i] = '1;
        default: ch[i] = CHAN_W'($urandom);
      endcase
    end
    send_pixel(col, row, ch[0], ch[1], ch[2]);
  endtask

  // Stop offering and wait until every owed result has come out, then let the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic scan;
    logic vig;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels with both effects on, as after reset: the center, the ramp
    // edges, the corners, off-screen coordinates, odd and even lines, channel extremes.
    send_pixel(160, 120, 255, 255, 255);
    send_pixel(160, 121, 255, 255, 255);
    send_pixel(0, 0, 255, 255, 255);
    send_pixel(319, 239, 255, 128, 1);
    send_pixel(260, 120, 200, 100, 50);
    send_pixel(261, 121, 200, 100, 50);
    send_pixel(360, 120, 255, 255, 255);
    send_pixel(359, 121, 255, 255, 255);
    send_pixel(300, 200, 255, 0, 255);
    send_pixel(0, 120, 255, 255, 255);
    send_pixel(160, 0, 255, 255, 255);
    send_pixel(1023, 1023, 255, 255, 255);
    send_pixel(1023, 0, 255, 255, 255);
    send_pixel(0, 1023, 255, 255, 255);
    send_pixel(512, 512, 170, 85, 255);
    send_pixel(5, 6, 0, 0, 0);
    send_pixel(161, 119, 1, 2, 3);
    send_pixel(80, 60, 4, 5, 9);
    drain();

    // Random phases through every enable combination, then a random one.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        scan = phase[0];
        vig  = phase[1];
      end else begin
        scan = 1'($urandom_range(0, 1));
        vig  = 1'($urandom_range(0, 1));
      end
      write_reg(REG_SCANLINE_EN, scan);
      write_reg(REG_VIGNETTE_EN, vig);
      if (phase == 2) squeeze_req <= 1'b1;
      repeat (217) random_pixel();
      drain();
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && backlog == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
